@@ design/lru_table_watermark_eviction_core_assert.svh @@
// Assertion macros for the LRU slot table with watermark eviction.
`ifndef LRU_TABLE_WATERMARK_EVICTION_CORE_ASSERT_SVH
`define LRU_TABLE_WATERMARK_EVICTION_CORE_ASSERT_SVH

// A holds at this edge, so B holds at the same edge.
`ifndef SYNTH
`define LTWE_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("ltwe: same-cycle check failed");
`else
`define LTWE_ASSERT_SAME(label, clk, rst, a, b)
`endif

// A holds at this edge, so B holds at the next edge.
`ifndef SYNTH
`define LTWE_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("ltwe: next-cycle check failed");
`else
`define LTWE_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

@@ design/ltwe_pkg.sv @@
// Shared constants, codes and control structs of the LRU slot table.
`default_nettype none

package ltwe_pkg;

   localparam int SLOTS   = 32;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);

   localparam int OP_W    = 2;
   localparam int TILE_W  = 5;
   localparam int NOW_W   = 32;
   localparam int OCC_W   = 6;
   localparam int WM_W    = 10;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [WM_W-1:0] HIGH_WM_RESET = 10'd512;
   localparam logic [WM_W-1:0] LOW_WM_RESET  = 10'd256;

   // register select: byte address bit 2
   localparam logic REG_HIGH_WM = 1'b0;
   localparam logic REG_LOW_WM  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_USE    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CHECK  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic load_item;
      logic apply;
      logic scan_issue;
      logic scan_first;
      logic evict;
      logic emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic evict_go;
      logic more;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ design/lru_table_watermark_eviction_core.sv @@
// Top level of the LRU slot table with high/low watermark eviction.
`default_nettype none

// LRU slot table with watermark eviction. Each of SLOTS slots keeps a present
// bit and a 32-bit last-use stamp in a single-port-read stamp memory. Every
// request word yields zero or more eviction words followed by one status word
// with last set. A remove, a clear, or a use or check that evicts nothing, is
// accepted, then applied with its status word loaded in the same cycle; when
// the result register is still full the status waits for it. When a check or
// use with evict-after evicts slots, each victim needs one full pass over the
// stamp memory, one slot read per cycle, then the finish state drains the
// compare and the evict state retires the victim. A new request is taken only
// once the previous one has loaded its status word; that word may still be
// waiting on rsp_ready. The stamp memory needs no clearing pass after reset.
// Registers: 0x0 high watermark (reset 512), 0x4 low watermark (reset 256).

module lru_table_watermark_eviction_core
   import ltwe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [TILE_W-1:0] req_tile,
   input  wire logic              req_tile_inited,
   input  wire logic [NOW_W-1:0]  req_now,
   input  wire logic              req_evict_after,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [TILE_W-1:0]      rsp_victim,
   output logic                   rsp_evicted,
   output logic [OCC_W-1:0]       rsp_occupancy,
   output logic                   rsp_last,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

`include "lru_table_watermark_eviction_core_assert.svh"

   logic [WM_W-1:0] high_wm_ff, high_wm_in;
   logic [WM_W-1:0] low_wm_ff, low_wm_in;
   logic            csr_wr;
   dp_cmd_type      cmd;
   dp_status_type   st;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      high_wm_in = high_wm_ff;
      low_wm_in  = low_wm_ff;
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_HIGH_WM: begin
            if (csr_wr) begin
               high_wm_in = csr_pwdata[WM_W-1:0];
            end
            csr_prdata = DATA_W'(high_wm_ff);
         end
         REG_LOW_WM: begin
            if (csr_wr) begin
               low_wm_in = csr_pwdata[WM_W-1:0];
            end
            csr_prdata = DATA_W'(low_wm_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_wm_ff <= HIGH_WM_RESET;
         low_wm_ff  <= LOW_WM_RESET;
      end else begin
         high_wm_ff <= high_wm_in;
         low_wm_ff  <= low_wm_in;
      end
   end

   ltwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ltwe_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .high_wm         (high_wm_ff),
      .low_wm          (low_wm_ff),
      .req_op          (req_op),
      .req_tile        (req_tile),
      .req_tile_inited (req_tile_inited),
      .req_now         (req_now),
      .req_evict_after (req_evict_after),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_victim      (rsp_victim),
      .rsp_evicted     (rsp_evicted),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last        (rsp_last)
   );

   // one request word in flight: no accept in the cycle after an accept
   `LTWE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // an eviction word is never the closing word
   `LTWE_ASSERT_SAME(a_evict_not_last, clock, reset, rsp_valid && rsp_evicted, !rsp_last)
   // occupancy never exceeds the slot count
   `LTWE_ASSERT_SAME(a_occ_bound, clock, reset, rsp_valid, rsp_occupancy <= OCC_W'(SLOTS))

endmodule

`default_nettype wire

@@ design/ltwe_ctrl.sv @@
// Sequencer for apply, stamp scan, eviction and status words.
`default_nettype none

module ltwe_ctrl
   import ltwe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type st,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_SCAN0,
      S_SCAN,
      S_FINISH,
      S_EVICT,
      S_STATUS
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (st.evict_go) begin
               state_in = S_SCAN0;
            end else if (st.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_SCAN0: begin
            cmd.scan_issue = 1'b1;
            cmd.scan_first = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (st.scan_last) begin
               state_in = S_FINISH;
            end
         end
         // let the last stamp read reach the compare
         S_FINISH: begin
            state_in = S_EVICT;
         end
         S_EVICT: begin
            if (st.out_free) begin
               cmd.evict = 1'b1;
               state_in  = st.more ? S_SCAN0 : S_STATUS;
            end
         end
         S_STATUS: begin
            if (st.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/ltwe_dp.sv @@
// Slot table datapath: present bits, stamp memory, minimum scan and result register.
`default_nettype none

module ltwe_dp
   import ltwe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_status_type          st,
   input  wire logic [WM_W-1:0]   high_wm,
   input  wire logic [WM_W-1:0]   low_wm,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [TILE_W-1:0] req_tile,
   input  wire logic              req_tile_inited,
   input  wire logic [NOW_W-1:0]  req_now,
   input  wire logic              req_evict_after,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [TILE_W-1:0]      rsp_victim,
   output logic                   rsp_evicted,
   output logic [OCC_W-1:0]       rsp_occupancy,
   output logic                   rsp_last
);

   // held input word
   op_type              op_ff;
   logic [TILE_W-1:0]   tile_ff;
   logic                inited_ff;
   logic [NOW_W-1:0]    now_ff;
   logic                evict_after_ff;

   // table state
   logic [SLOTS-1:0]    present_ff, present_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [NOW_W-1:0]    stamp_mem [SLOTS];
   logic                mem_we;

   // scan
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]   rd_addr;
   logic [NOW_W-1:0]    stamp_rd_ff;
   logic                cmp_valid_ff;
   logic [SLOT_W-1:0]   cmp_idx_ff;
   logic                best_valid_ff;
   logic [SLOT_W-1:0]   best_idx_ff;
   logic [NOW_W-1:0]    best_stamp_ff;
   logic                take;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TILE_W-1:0]   victim_ff;
   logic                evicted_ff;
   logic [OCC_W-1:0]    occ_ff;
   logic                last_ff;
   logic                rsp_load;

   logic [SLOT_W-1:0]   tile_idx;
   logic                tile_ok;
   logic                check_req;
   logic [WM_W-1:0]     target;
   logic [WM_W-1:0]     count_wide;

   assign tile_idx  = SLOT_W'(tile_ff);
   assign tile_ok   = (7'(tile_ff) < 7'(SLOTS));
   assign check_req = ((op_ff == OP_USE) && evict_after_ff) || (op_ff == OP_CHECK);
   assign target    = (low_wm < high_wm) ? low_wm : high_wm;

   // table update for the apply and evict steps
   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      mem_we     = 1'b0;
      if (cmd.apply) begin
         case (op_ff)
            OP_USE: begin
               if (inited_ff && tile_ok) begin
                  mem_we = 1'b1;
                  if (!present_ff[tile_idx]) begin
                     present_in[tile_idx] = 1'b1;
                     count_in             = COUNT_W'(count_ff + 1'b1);
                  end
               end
            end
            OP_REMOVE: begin
               if (tile_ok && present_ff[tile_idx]) begin
                  present_in[tile_idx] = 1'b0;
                  count_in             = COUNT_W'(count_ff - 1'b1);
               end
            end
            OP_CHECK: begin
               count_in = count_ff;
            end
            OP_CLEAR: begin
               present_in = '0;
               count_in   = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end else if (cmd.evict) begin
         present_in[best_idx_ff] = 1'b0;
         count_in                = COUNT_W'(count_ff - 1'b1);
      end
   end

   assign count_wide = WM_W'(count_in);

   always_comb begin
      st.evict_go  = check_req && (high_wm != '0) && (count_wide > high_wm);
      st.more      = (count_wide > target);
      st.scan_last = (rd_addr == SLOT_W'(SLOTS - 1));
      st.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // scan address: restart at slot 0 on the first issue
   assign rd_addr     = cmd.scan_first ? '0 : scan_idx_ff;
   assign scan_idx_in = SLOT_W'(rd_addr + 1'b1);

   // strict less-than keeps the lowest index on equal stamps
   assign take = cmp_valid_ff && present_ff[cmp_idx_ff]
                 && (!best_valid_ff || (stamp_rd_ff < best_stamp_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[tile_idx] <= now_ff;
      end
      stamp_rd_ff <= stamp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff          <= op_type'(req_op);
         tile_ff        <= req_tile;
         inited_ff      <= req_tile_inited;
         now_ff         <= req_now;
         evict_after_ff <= req_evict_after;
      end
      if (cmd.scan_issue) begin
         scan_idx_ff <= scan_idx_in;
      end
      cmp_idx_ff <= rd_addr;
      if (take) begin
         best_idx_ff   <= cmp_idx_ff;
         best_stamp_ff <= stamp_rd_ff;
      end
      if (rsp_load) begin
         victim_ff  <= cmd.evict ? TILE_W'(best_idx_ff) : '0;
         evicted_ff <= cmd.evict;
         occ_ff     <= OCC_W'(count_in);
         last_ff    <= cmd.emit_status;
      end
   end

   assign rsp_load     = cmd.evict || cmd.emit_status;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         count_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         present_ff   <= present_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmd.scan_issue;
         if (cmd.scan_first) begin
            best_valid_ff <= 1'b0;
         end else if (take) begin
            best_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_victim    = victim_ff;
   assign rsp_evicted   = evicted_ff;
   assign rsp_occupancy = occ_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

@@ sim/lru_table_watermark_eviction_core_tb.sv @@
// Self-checking testbench for the LRU slot table with watermark eviction.
`default_nettype none

module lru_table_watermark_eviction_core_tb
   import ltwe_pkg::*;
();

   localparam logic [ADDR_W-1:0] HIGH_WM_ADDR = {REG_HIGH_WM, 2'b00};
   localparam logic [ADDR_W-1:0] LOW_WM_ADDR  = {REG_LOW_WM, 2'b00};
   localparam int HOLD_CYCLES   = 400;
   localparam int GAP_MAX       = 40;
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic [TILE_W-1:0] victim;
      logic              evicted;
      logic [OCC_W-1:0]  occupancy;
      logic              last;
   } report_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_op          = '0;
   logic [TILE_W-1:0] req_tile        = '0;
   logic              req_tile_inited = 1'b0;
   logic [NOW_W-1:0]  req_now         = '0;
   logic              req_evict_after = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic [TILE_W-1:0] rsp_victim;
   logic              rsp_evicted;
   logic [OCC_W-1:0]  rsp_occupancy;
   logic              rsp_last;
   logic              csr_psel        = 1'b0;
   logic              csr_penable     = 1'b0;
   logic              csr_pwrite      = 1'b0;
   logic [ADDR_W-1:0] csr_paddr       = '0;
   logic [DATA_W-1:0] csr_pwdata      = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // shadow of the slot table
   logic             slot_present [SLOTS];
   logic [NOW_W-1:0] slot_stamp [SLOTS];
   int               slot_count;
   int               wm_high;
   int               wm_low;
   report_type       due_reports [$];

   int               fail_count    = 0;
   int               send_idle_pct = 0;
   int               stall_pct     = 0;
   int               hold_asked    = 0;
   int               hold_done     = 0;
   int               hold_left     = 0;
   logic [NOW_W-1:0] stamp_clock;
   report_type       seen;

   always #1 clock = ~clock;

   lru_table_watermark_eviction_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_tile        (req_tile),
      .req_tile_inited (req_tile_inited),
      .req_now         (req_now),
      .req_evict_after (req_evict_after),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_victim      (rsp_victim),
      .rsp_evicted     (rsp_evicted),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void queue_report(logic [TILE_W-1:0] victim, logic evicted, logic last);
      report_type r;
      r.victim    = victim;
      r.evicted   = evicted;
      r.occupancy = OCC_W'(slot_count);
      r.last      = last;
      due_reports.insert(due_reports.size(), r);
   endfunction

   function automatic void evict_to_watermark();
      int target;
      int oldest;
      if (wm_high == 0 || slot_count <= wm_high)
         return;
      target = (wm_low < wm_high) ? wm_low : wm_high;
      while (slot_count > target) begin
         oldest = -1;
         // strict compare keeps the lowest index on equal stamps
         for (int i = 0; i < SLOTS; i++)
            if (slot_present[i] && (oldest < 0 || slot_stamp[i] < slot_stamp[oldest]))
               oldest = i;
         if (oldest < 0)
            break;
         slot_present[oldest] = 1'b0;
         slot_count--;
         queue_report(TILE_W'(oldest), 1'b1, 1'b0);
      end
   endfunction

   function automatic void apply_to_table(op_type op, logic [TILE_W-1:0] tile, logic inited,
                                          logic [NOW_W-1:0] now, logic evict_after);
      case (op)
         OP_USE: begin
            if (inited && tile < SLOTS) begin
               if (!slot_present[tile]) begin
                  slot_present[tile] = 1'b1;
                  slot_count++;
               end
               slot_stamp[tile] = now;
            end
            if (evict_after)
               evict_to_watermark();
         end
         OP_REMOVE: begin
            if (tile < SLOTS && slot_present[tile]) begin
               slot_present[tile] = 1'b0;
               slot_count--;
            end
         end
         OP_CHECK: begin
            evict_to_watermark();
         end
         OP_CLEAR: begin
            foreach (slot_present[i])
               slot_present[i] = 1'b0;
            slot_count = 0;
         end
      endcase
      queue_report('0, 1'b0, 1'b1);
   endfunction

   // result side: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_done != hold_asked) begin
         hold_done <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_reports.size() == 0) begin
            $error("result word with none due: victim %0d evicted %0b occupancy %0d last %0b",
                   rsp_victim, rsp_evicted, rsp_occupancy, rsp_last);
            fail_count++;
         end else begin
            seen = due_reports.pop_front();
            compare_field("victim", 32'(seen.victim), 32'(rsp_victim));
            compare_field("evicted", 32'(seen.evicted), 32'(rsp_evicted));
            compare_field("occupancy", 32'(seen.occupancy), 32'(rsp_occupancy));
            compare_field("last", 32'(seen.last), 32'(rsp_last));
         end
      end
   end

   task automatic send_word(op_type op, logic [TILE_W-1:0] tile, logic inited,
                            logic [NOW_W-1:0] now, logic evict_after);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_tile        <= tile;
      req_tile_inited <= inited;
      req_now         <= now;
      req_evict_after <= evict_after;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      apply_to_table(op, tile, inited, now, evict_after);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [DATA_W-1:0] value;
      csr_read(HIGH_WM_ADDR, value);
      compare_field("high_watermark", 32'(wm_high), 32'(value[WM_W-1:0]));
      csr_read(LOW_WM_ADDR, value);
      compare_field("low_watermark", 32'(wm_low), 32'(value[WM_W-1:0]));
   endtask

   // upper data bits are junk: only the low watermark bits count
   task automatic set_watermarks(int high, int low);
      logic [DATA_W-1:0] word;
      wait_results_done();
      word = $urandom;
      word[WM_W-1:0] = high[WM_W-1:0];
      csr_write(HIGH_WM_ADDR, word);
      wm_high = int'(word[WM_W-1:0]);
      word = $urandom;
      word[WM_W-1:0] = low[WM_W-1:0];
      csr_write(LOW_WM_ADDR, word);
      wm_low = int'(word[WM_W-1:0]);
      check_registers();
   endtask

   task automatic send_random_word();
      int               pick;
      op_type           op;
      logic [TILE_W-1:0] tile;
      logic             inited;
      logic [NOW_W-1:0] now;
      logic             evict_after;
      pick        = $urandom_range(99);
      tile        = TILE_W'($urandom_range(SLOTS - 1));
      inited      = 1'($urandom_range(1));
      now         = $urandom;
      evict_after = 1'($urandom_range(1));
      stamp_clock = stamp_clock + $urandom_range(3);
      if (pick < 58) begin
         op          = OP_USE;
         inited      = ($urandom_range(9) != 0);
         evict_after = ($urandom_range(3) == 0);
         // mostly a rising clock, so stamps tie and wrap now and then
         if ($urandom_range(9) != 0)
            now = stamp_clock;
      end else if (pick < 72) begin
         op = OP_REMOVE;
      end else if (pick < 88) begin
         op = OP_CHECK;
      end else if (pick < 90) begin
         op = OP_CLEAR;
      end else begin
         op = op_type'($urandom_range(3));
      end
      send_word(op, tile, inited, now, evict_after);
   endtask

   task automatic test_register_reset();
      check_registers();
   endtask

   task automatic test_basic_ops();
      send_word(OP_USE, 5'd0, 1'b1, 32'h0000_0000, 1'b1);
      send_word(OP_USE, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_word(OP_USE, 5'd5, 1'b0, 32'h0000_1234, 1'b1);
      send_word(OP_USE, 5'd0, 1'b1, 32'h0000_0007, 1'b0);
      send_word(OP_REMOVE, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_word(OP_REMOVE, 5'd31, 1'b0, 32'h0000_0000, 1'b0);
      send_word(OP_CHECK, 5'd0, 1'b0, 32'h0000_0000, 1'b0);
      send_word(OP_CLEAR, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b1);
      wait_results_done();
   endtask

   task automatic test_eviction_order();
      set_watermarks(1, 0);
      send_word(OP_USE, 5'd3, 1'b1, 32'd100, 1'b0);
      send_word(OP_USE, 5'd1, 1'b1, 32'd100, 1'b0);
      send_word(OP_USE, 5'd2, 1'b1, 32'd100, 1'b0);
      send_word(OP_USE, 5'd6, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_word(OP_CHECK, 5'd0, 1'b0, 32'h0000_0000, 1'b0);
      wait_results_done();
   endtask

   task automatic test_watermark_limits();
      set_watermarks(1023, 1023);
      send_word(OP_USE, 5'd9, 1'b1, 32'd50, 1'b1);
      send_word(OP_CHECK, 5'd9, 1'b1, 32'd50, 1'b1);
      set_watermarks(0, 0);
      send_word(OP_USE, 5'd10, 1'b1, 32'h8000_0000, 1'b1);
      send_word(OP_USE, 5'd11, 1'b1, 32'd5, 1'b1);
      send_word(OP_CHECK, 5'd0, 1'b0, 32'h0000_0000, 1'b0);
      // low above high: high is the target
      set_watermarks(2, 1023);
      send_word(OP_USE, 5'd12, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_word(OP_CLEAR, 5'd0, 1'b0, 32'h0000_0000, 1'b0);
      wait_results_done();
   endtask

   // fill every slot behind a stalled result side, then evict the lot
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct <= 0;
      set_watermarks(31, 0);
      hold_asked <= hold_asked + 1;
      for (int i = 0; i < SLOTS; i++)
         send_word(OP_USE, TILE_W'(i), 1'b1, $urandom, (i == SLOTS - 1));
      wait_results_done();
   endtask

   task automatic test_random_traffic(int words, int idle_pct, int stall, int high, int low);
      set_watermarks(high, low);
      send_idle_pct = idle_pct;
      stall_pct <= stall;
      repeat (words) send_random_word();
      wait_results_done();
   endtask

   initial begin
      foreach (slot_present[i])
         slot_present[i] = 1'b0;
      slot_count  = 0;
      wm_high     = int'(HIGH_WM_RESET);
      wm_low      = int'(LOW_WM_RESET);
      stamp_clock = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_basic_ops();
      test_eviction_order();
      test_watermark_limits();
      test_backpressure();
      test_random_traffic(40, 0, 0, $urandom_range(3, 12), $urandom_range(0, 3));
      test_random_traffic(40, 78, 0, $urandom_range(2, 10), $urandom_range(11, 1023));
      test_random_traffic(40, 0, 78, $urandom_range(1, 31), $urandom_range(0, 31));
      test_random_traffic(39, 21, 21, $urandom_range(2, 12), $urandom_range(0, 12));
      if (fail_count == 0)
         $display("lru_table_watermark_eviction_core_tb: PASS");
      else
         $display("lru_table_watermark_eviction_core_tb: FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("lru_table_watermark_eviction_core_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/ltwe_pkg.sv
design/ltwe_ctrl.sv
design/ltwe_dp.sv
design/lru_table_watermark_eviction_core.sv
sim/lru_table_watermark_eviction_core_tb.sv
